/* rtl/hrd_pkg.sv */
// Shared constants, match keys and types for the HTTP request end detector.
`timescale 1ns / 1ps

package hrd_pkg;

    localparam int COUNT_WIDTH_DEF = 28;
    localparam int CFG_W           = 28;
    localparam int LEN_W           = 31;
    localparam int OUT_CNT_W       = 28;
    localparam int STATUS_W        = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 28'd10485760;
    localparam logic [0:0]       REG_MAX_BYTES   = 1'b0;

    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE   = 2'd2;

    // matcher phases
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_DIG0  = 8'h30;
    localparam logic [7:0] CHR_DIG9  = 8'h39;

    localparam logic [23:0]      HDR_TAIL = 24'h0D0A0D;
    localparam logic [LEN_W-1:0] LEN_MAX  = '1;

    localparam int CL_KEY_LEN = 15;
    localparam int TE_KEY_LEN = 18;
    localparam int CK_KEY_LEN = 7;
    localparam logic [8*CL_KEY_LEN-1:0] CL_KEY = "Content-Length:";
    localparam logic [8*TE_KEY_LEN-1:0] TE_KEY = "Transfer-Encoding:";
    localparam logic [8*CK_KEY_LEN-1:0] CK_KEY = "CHUNKED";

    localparam logic [2:0] TERM_DONE  = 3'd5;
    localparam logic [3:0] METH_SAT   = 4'd15;

    typedef struct packed {
        logic [3:0]       method_count;
        logic [3:0]       method_cand;
        logic             method_closed;
        logic [3:0]       len_idx;
        logic [1:0]       len_phase;
        logic [LEN_W-1:0] len_value;
        logic [4:0]       enc_idx;
        logic [1:0]       enc_phase;
        logic [2:0]       enc_cmp;
        logic             chunked;
        logic             zero_seen;
    } t_match_state;

    localparam t_match_state MATCH_RESET = '{
        method_count:  4'd0,
        method_cand:   4'hF,
        method_closed: 1'b0,
        len_idx:       4'd0,
        len_phase:     PH_SEARCH,
        len_value:     '0,
        enc_idx:       5'd0,
        enc_phase:     PH_SEARCH,
        enc_cmp:       3'd0,
        chunked:       1'b0,
        zero_seen:     1'b0
    };

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHR_SP) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] c;
        c = '0;
        if (idx < 4'(CL_KEY_LEN)) c = CL_KEY[8*(CL_KEY_LEN-1-int'(idx)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] idx);
        logic [7:0] c;
        c = '0;
        if (idx < 5'(TE_KEY_LEN)) c = TE_KEY[8*(TE_KEY_LEN-1-int'(idx)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] idx);
        logic [7:0] c;
        c = '0;
        if (idx < 3'(CK_KEY_LEN)) c = CK_KEY[8*(CK_KEY_LEN-1-int'(idx)) +: 8];
        return c;
    endfunction

    // GET, HEAD, DELETE, OPTIONS, left aligned in 8 bytes
    function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [2:0] pos);
        logic [63:0] nm;
        unique case (k)
            2'd0: nm = {"GET", 40'h0};
            2'd1: nm = {"HEAD", 32'h0};
            2'd2: nm = {"DELETE", 16'h0};
            2'd3: nm = {"OPTIONS", 8'h0};
            default: nm = '0;
        endcase
        return nm[8*(7-int'(pos)) +: 8];
    endfunction

    function automatic logic [3:0] meth_len(input logic [1:0] k);
        logic [3:0] n;
        unique case (k)
            2'd0: n = 4'd3;
            2'd1: n = 4'd4;
            2'd2: n = 4'd6;
            2'd3: n = 4'd7;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // body terminator 0 CR LF CR LF
    function automatic logic [7:0] end_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = CHR_DIG0;
            3'd1: c = CHR_CR;
            3'd2: c = CHR_LF;
            3'd3: c = CHR_CR;
            3'd4: c = CHR_LF;
            default: c = CHR_NUL;
        endcase
        return c;
    endfunction

endpackage

/* rtl/hrd_ifs.sv */
// Valid/ready channel interfaces for request bytes and detector results.
`timescale 1ns / 1ps

interface hrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hrd_out_if;
    logic                           valid;
    logic                           ready;
    logic [hrd_pkg::STATUS_W-1:0]   status;
    logic                           header_done;
    logic                           bodiless_method;
    logic                           chunked_body;
    logic [hrd_pkg::LEN_W-1:0]      declared_length;
    logic [hrd_pkg::OUT_CNT_W-1:0]  header_bytes;
    logic [hrd_pkg::OUT_CNT_W-1:0]  body_bytes;

    modport source (output valid, output status, output header_done, output bodiless_method,
                    output chunked_body, output declared_length, output header_bytes,
                    output body_bytes, input ready);
    modport sink   (input valid, input status, input header_done, input bodiless_method,
                    input chunked_body, input declared_length, input header_bytes,
                    input body_bytes, output ready);
endinterface

/* rtl/hrd_cfg_regs.sv */
// APB register block holding the request byte limit.
`timescale 1ns / 1ps

module hrd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrd_pkg::PADDR_W-1:0]   paddr,
    input  logic [hrd_pkg::PDATA_W-1:0]   pwdata,
    output logic [hrd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [hrd_pkg::CFG_W-1:0]     o_max_bytes
);
    import hrd_pkg::*;

    logic [CFG_W-1:0] r_max_bytes;
    logic             hit_max;

    assign hit_max = (paddr[PADDR_W-1] == REG_MAX_BYTES);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (psel && penable && pwrite && hit_max) begin
            r_max_bytes <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata      = hit_max ? {{(PDATA_W-CFG_W){1'b0}}, r_max_bytes} : '0;
    assign o_max_bytes = r_max_bytes;

endmodule

/* rtl/hrd_field_match.sv */
// Header field matchers: method, Content-Length value and chunked encoding.
`timescale 1ns / 1ps

module hrd_field_match (
    input  hrd_pkg::t_match_state i_cur,
    input  logic [7:0]            i_byte,
    output hrd_pkg::t_match_state o_next
);
    import hrd_pkg::*;

    always_comb begin : p_next
        t_match_state     nx;
        logic [7:0]       ub;
        logic [LEN_W+3:0] prod;
        logic             digit;
        nx    = i_cur;
        ub    = to_upper(i_byte);
        digit = (i_byte >= CHR_DIG0) && (i_byte <= CHR_DIG9);
        // value * 10 + digit
        prod  = ({4'b0, i_cur.len_value} << 3) + ({4'b0, i_cur.len_value} << 1)
              + {{(LEN_W){1'b0}}, i_byte[3:0]};

        if (i_byte == CHR_NUL) begin
            // NUL stops all header searches for the rest of the header
            nx.zero_seen = 1'b1;
            if (!i_cur.method_closed) begin
                nx.method_closed = 1'b1;
                nx.method_cand   = '0;
            end
            if (i_cur.len_phase != PH_SEARCH) nx.len_phase = PH_DONE;
            if (i_cur.enc_phase != PH_SEARCH) nx.enc_phase = PH_DONE;
        end else if (!i_cur.zero_seen) begin
            // method
            if (!i_cur.method_closed) begin
                if (i_byte == CHR_SP) begin
                    for (int k = 0; k < 4; k++) begin
                        if (meth_len(2'(k)) != i_cur.method_count) nx.method_cand[k] = 1'b0;
                    end
                    nx.method_closed = 1'b1;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        if (i_cur.method_count >= meth_len(2'(k)) ||
                            ub != meth_char(2'(k), i_cur.method_count[2:0])) begin
                            nx.method_cand[k] = 1'b0;
                        end
                    end
                    if (i_cur.method_count != METH_SAT) begin
                        nx.method_count = i_cur.method_count + 4'd1;
                    end
                end
            end

            // Content-Length
            unique case (i_cur.len_phase)
                PH_SEARCH: begin
                    if (i_byte == cl_char(i_cur.len_idx)) begin
                        if (i_cur.len_idx == 4'(CL_KEY_LEN - 1)) begin
                            nx.len_idx   = '0;
                            nx.len_phase = PH_SKIP;
                        end else begin
                            nx.len_idx = i_cur.len_idx + 4'd1;
                        end
                    end else begin
                        nx.len_idx = (i_byte == cl_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                end
                PH_SKIP, PH_VALUE: begin
                    if (!(i_cur.len_phase == PH_SKIP && is_ws(i_byte))) begin
                        if (digit) begin
                            nx.len_value = (prod > {4'b0, LEN_MAX}) ? LEN_MAX
                                                                     : prod[LEN_W-1:0];
                            nx.len_phase = PH_VALUE;
                        end else begin
                            nx.len_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Transfer-Encoding
            unique case (i_cur.enc_phase)
                PH_SEARCH: begin
                    if (i_byte == te_char(i_cur.enc_idx)) begin
                        if (i_cur.enc_idx == 5'(TE_KEY_LEN - 1)) begin
                            nx.enc_idx   = '0;
                            nx.enc_phase = PH_SKIP;
                        end else begin
                            nx.enc_idx = i_cur.enc_idx + 5'd1;
                        end
                    end else begin
                        nx.enc_idx = (i_byte == te_char(5'd0)) ? 5'd1 : 5'd0;
                    end
                end
                PH_SKIP, PH_VALUE: begin
                    if (!(i_cur.enc_phase == PH_SKIP && is_ws(i_byte))) begin
                        nx.enc_phase = PH_VALUE;
                        if (ub == ck_char(i_cur.enc_cmp)) begin
                            nx.enc_cmp = i_cur.enc_cmp + 3'd1;
                            if (i_cur.enc_cmp == 3'(CK_KEY_LEN - 1)) begin
                                nx.chunked   = 1'b1;
                                nx.enc_phase = PH_DONE;
                            end
                        end else begin
                            nx.enc_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_next = nx;
    end

endmodule

/* rtl/hrd_core.sv */
// Byte pipeline: input register, request state update and result register.
`timescale 1ns / 1ps

module hrd_core #(
    parameter int COUNT_WIDTH = hrd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [hrd_pkg::CFG_W-1:0] i_max_bytes,
    hrd_in_if.sink                    i_req,
    hrd_out_if.source                 o_res
);
    import hrd_pkg::*;

    // input stage
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_first;

    // request state
    logic [COUNT_WIDTH-1:0] r_total, r_hdr_len, r_body;
    logic [23:0]            r_recent;
    logic                   r_hdr_seen, r_complete, r_oversize;
    logic [2:0]             r_term;
    t_match_state           r_match;

    // result stage
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_hdr_done, r_bodiless, r_chunked;
    logic [LEN_W-1:0]       r_decl_len;
    logic [OUT_CNT_W-1:0]   r_hdr_bytes, r_body_bytes;

    // state seen by the word in stage 1 (cleared when it opens a request)
    logic [COUNT_WIDTH-1:0] c_total, c_hdr_len, c_body;
    logic [23:0]            c_recent;
    logic                   c_hdr_seen, c_complete, c_oversize;
    logic [2:0]             c_term;
    t_match_state           c_match, m_next;

    logic [COUNT_WIDTH-1:0] n_total, n_hdr_len, n_body;
    logic [23:0]            n_recent;
    logic                   n_hdr_seen, n_complete, n_oversize;
    logic [2:0]             n_term;
    t_match_state           n_match;
    logic                   n_bodiless;
    logic [STATUS_W-1:0]    n_status;

    logic [COUNT_WIDTH-1:0]           inc_total, inc_body;
    logic [32+COUNT_WIDTH-1:0]        total_wide, body_wide;
    logic [31:0]                      total32, body32, max32;
    logic [OUT_CNT_W+COUNT_WIDTH-1:0] hl_ext, body_ext;

    logic adv, in_ready, in_take;

    assign adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_s1_valid || adv;
    assign in_take  = i_req.valid && in_ready;

    assign c_total    = r_s1_first ? '0 : r_total;
    assign c_hdr_len  = r_s1_first ? '0 : r_hdr_len;
    assign c_body     = r_s1_first ? '0 : r_body;
    assign c_recent   = r_s1_first ? '0 : r_recent;
    assign c_hdr_seen = r_s1_first ? 1'b0 : r_hdr_seen;
    assign c_complete = r_s1_first ? 1'b0 : r_complete;
    assign c_oversize = r_s1_first ? 1'b0 : r_oversize;
    assign c_term     = r_s1_first ? '0 : r_term;
    assign c_match    = r_s1_first ? MATCH_RESET : r_match;

    hrd_field_match u_match (
        .i_cur  (c_match),
        .i_byte (r_s1_byte),
        .o_next (m_next)
    );

    assign inc_total  = c_total + 1'b1;
    assign inc_body   = c_body + 1'b1;
    assign total_wide = {32'b0, inc_total};
    assign body_wide  = {32'b0, inc_body};
    assign total32    = total_wide[31:0];
    assign body32     = body_wide[31:0];
    assign max32      = {{(32-CFG_W){1'b0}}, i_max_bytes};

    always_comb begin
        n_total    = c_total;
        n_hdr_len  = c_hdr_len;
        n_body     = c_body;
        n_recent   = c_recent;
        n_hdr_seen = c_hdr_seen;
        n_complete = c_complete;
        n_oversize = c_oversize;
        n_term     = c_term;
        n_match    = c_match;
        n_bodiless = c_match.method_closed && (|c_match.method_cand);

        if (!c_complete && !c_oversize) begin
            if (&c_total) begin
                // byte counter full
                n_oversize = 1'b1;
            end else begin
                n_total = inc_total;
                if (!c_hdr_seen) begin
                    n_match = m_next;
                    if (c_recent == HDR_TAIL && r_s1_byte == CHR_LF) begin
                        n_hdr_seen = 1'b1;
                        n_hdr_len  = inc_total;
                    end
                end else begin
                    n_body = inc_body;
                    if (c_term != TERM_DONE) begin
                        if (r_s1_byte == end_char(c_term)) n_term = c_term + 3'd1;
                        else n_term = (r_s1_byte == end_char(3'd0)) ? 3'd1 : 3'd0;
                    end
                end
                n_recent   = {c_recent[15:0], r_s1_byte};
                n_bodiless = n_match.method_closed && (|n_match.method_cand);

                if (n_hdr_seen) begin
                    priority if (n_bodiless) begin
                        n_complete = 1'b1;
                    end else if (n_match.len_value != '0) begin
                        if (c_hdr_seen && body32 >= {1'b0, n_match.len_value})
                            n_complete = 1'b1;
                    end else if (n_match.chunked) begin
                        if (n_term == TERM_DONE) n_complete = 1'b1;
                    end else begin
                        if (c_hdr_seen && inc_body != '0) n_complete = 1'b1;
                    end
                end
                if (!n_complete && total32 > max32) n_oversize = 1'b1;
            end
        end

        n_status = n_complete ? ST_COMPLETE : (n_oversize ? ST_OVERSIZE : ST_INCOMPLETE);
    end

    assign hl_ext   = {{OUT_CNT_W{1'b0}}, n_hdr_len};
    assign body_ext = {{OUT_CNT_W{1'b0}}, n_body};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte  <= i_req.data_byte;
            r_s1_first <= i_req.first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_hdr_len  <= '0;
            r_body     <= '0;
            r_recent   <= '0;
            r_hdr_seen <= 1'b0;
            r_complete <= 1'b0;
            r_oversize <= 1'b0;
            r_term     <= '0;
            r_match    <= MATCH_RESET;
        end else if (adv) begin
            r_total    <= n_total;
            r_hdr_len  <= n_hdr_len;
            r_body     <= n_body;
            r_recent   <= n_recent;
            r_hdr_seen <= n_hdr_seen;
            r_complete <= n_complete;
            r_oversize <= n_oversize;
            r_term     <= n_term;
            r_match    <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status     <= n_status;
            r_hdr_done   <= n_hdr_seen;
            r_bodiless   <= n_bodiless;
            r_chunked    <= n_match.chunked;
            r_decl_len   <= n_match.len_value;
            r_hdr_bytes  <= n_hdr_seen ? hl_ext[OUT_CNT_W-1:0] : '0;
            r_body_bytes <= n_hdr_seen ? body_ext[OUT_CNT_W-1:0] : '0;
        end
    end

    assign i_req.ready           = in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_status;
    assign o_res.header_done     = r_hdr_done;
    assign o_res.bodiless_method = r_bodiless;
    assign o_res.chunked_body    = r_chunked;
    assign o_res.declared_length = r_decl_len;
    assign o_res.header_bytes    = r_hdr_bytes;
    assign o_res.body_bytes      = r_body_bytes;

endmodule

/* rtl/http_request_end_detector_unit.sv */
// HTTP request end detector top level: APB limit register and byte pipeline.
// Flow: a taken byte is held in the input register; its result is registered in the
// result register when that is free; while the sink holds a result, the byte waits.
// Throughput: one byte per cycle while the sink takes each result.
// Reset: synchronous, active low; clears request state, limit returns to 10485760.
`timescale 1ns / 1ps

module http_request_end_detector_unit #(
    parameter int COUNT_WIDTH = hrd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrd_pkg::PADDR_W-1:0]   paddr,
    input  logic [hrd_pkg::PDATA_W-1:0]   pwdata,
    output logic [hrd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    hrd_in_if.sink                        i_req,
    hrd_out_if.source                     o_res
);
    import hrd_pkg::*;

    logic [CFG_W-1:0] w_max_bytes;

    hrd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_bytes (w_max_bytes)
    );

    hrd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_bytes (w_max_bytes),
        .i_req       (i_req),
        .o_res       (o_res)
    );

    // counts stay zero until the header ends
    a_counts_before_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.header_done) |->
            (o_res.header_bytes == '0 && o_res.body_bytes == '0))
        else $error("header/body counts nonzero before header end");

    a_complete_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_COMPLETE) |-> o_res.header_done)
        else $error("request complete without header end");

    a_limit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[PADDR_W-1] == REG_MAX_BYTES) |=>
            (w_max_bytes == $past(pwdata[CFG_W-1:0])))
        else $error("limit register write lost");

endmodule
